FILE: sv/tebc_pkg.sv
// ----------------------------------------------------------------------------
// tebc_pkg
// Types and codes shared by the terminal escape byte classifier files.
// ----------------------------------------------------------------------------
package tebc_pkg;

  // parser mode
  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_PARAM = 2'd2,
    MODE_INTER = 2'd3
  } mode_t;

  // kind of the run that is open
  typedef enum logic [1:0] {
    RUN_NONE    = 2'd0,
    RUN_CONTENT = 2'd1,
    RUN_DIGIT   = 2'd2,
    RUN_PRIV    = 2'd3
  } run_t;

  // role of one byte
  typedef enum logic [3:0] {
    K_CONTENT = 4'd0,
    K_NEWLINE = 4'd1,
    K_ESC     = 4'd2,
    K_FE      = 4'd3,
    K_DIGIT   = 4'd4,
    K_COLON   = 4'd5,
    K_SEMI    = 4'd6,
    K_PRIV    = 4'd7,
    K_INTER   = 4'd8,
    K_FINAL   = 4'd9,
    K_UNKNOWN = 4'd10
  } kind_t;

  // parser state carried from byte to byte
  typedef struct packed {
    mode_t mode;
    logic  intro;
    run_t  run;
  } pstate_t;

  // classification of one byte
  typedef struct packed {
    kind_t kind;
    logic  run_start;
    logic  seq_end;
  } part_t;

  // byte codes
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_CSI     = 8'h5b;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_SEMI    = 8'h3b;

endpackage

FILE: sv/terminal_escape_byte_classifier_unit.sv
// ----------------------------------------------------------------------------
// terminal_escape_byte_classifier_unit
// Tags each byte of a terminal output stream with its role in the stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw byte per word, taken when in_tvalid and in_tready are high.
//   out_* : the same byte back with its role: part kind, run start flag, and
//           out_tlast set on the byte that completes an escape sequence.
//   An accepted input word is captured in the input register, classified by
//   short logic against the parser state, and stored in the result register,
//   which drives out_tvalid. One word per cycle is sustained while the
//   receiver keeps out_tready high; the parser state register is the only
//   loop.
//   When the receiver stalls the result register holds its word, the input
//   register still takes one more byte, and in_tready drops only while both
//   are full and out_tready is low.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to text mode with no run open.
// ----------------------------------------------------------------------------
module terminal_escape_byte_classifier_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] byte_out
  output logic [4:0] out_tuser,  // [3:0] part_kind, [4] run_start
  output logic       out_tlast   // seq_end
);

  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              out_vld_r;
  logic [7:0]        out_byte_r;
  tebc_pkg::part_t   out_part_r;
  tebc_pkg::pstate_t st_r;
  tebc_pkg::pstate_t st_nxt;
  tebc_pkg::part_t   part;
  logic              out_free;
  logic              adv;

  // pipeline handshake
  assign out_free  = !out_vld_r || out_tready;
  assign adv       = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // classification
  tebc_classify u_classify (
    .byte_i (in_byte_r),
    .st_i   (st_r),
    .st_nxt (st_nxt),
    .part_o (part)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode  <= tebc_pkg::MODE_TEXT;
      st_r.intro <= 1'b0;
      st_r.run   <= tebc_pkg::RUN_NONE;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= in_byte_r;
      out_part_r <= part;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_part_r.run_start, out_part_r.kind};
  assign out_tlast  = out_part_r.seq_end;

  // the introducer flag only lives in control parameter mode
  a_intro_mode: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.intro |-> st_r.mode == tebc_pkg::MODE_PARAM)
    else $error("introducer flag outside parameter mode");

  // a content run is open only in text mode
  a_content_text: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.run == tebc_pkg::RUN_CONTENT |-> st_r.mode == tebc_pkg::MODE_TEXT)
    else $error("content run open outside text mode");

  // digit and private runs are open only in parameter mode
  a_param_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.run == tebc_pkg::RUN_DIGIT || st_r.run == tebc_pkg::RUN_PRIV)
    |-> st_r.mode == tebc_pkg::MODE_PARAM)
    else $error("parameter run open outside parameter mode");

  // sequence end is only flagged on fe, final or unknown bytes
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_part_r.seq_end) |->
    (out_part_r.kind == tebc_pkg::K_FE || out_part_r.kind == tebc_pkg::K_FINAL ||
     out_part_r.kind == tebc_pkg::K_UNKNOWN))
    else $error("sequence end on wrong byte kind");

  // run start is only flagged on content, digit or private bytes
  a_start_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_part_r.run_start) |->
    (out_part_r.kind == tebc_pkg::K_CONTENT || out_part_r.kind == tebc_pkg::K_DIGIT ||
     out_part_r.kind == tebc_pkg::K_PRIV))
    else $error("run start on wrong byte kind");

endmodule

FILE: sv/tebc_classify.sv
// ----------------------------------------------------------------------------
// tebc_classify
// Combinational byte classifier: role of one byte and the next parser state.
// ----------------------------------------------------------------------------
module tebc_classify (
  input  logic [7:0]        byte_i,
  input  tebc_pkg::pstate_t st_i,
  output tebc_pkg::pstate_t st_nxt,
  output tebc_pkg::part_t   part_o
);

  // byte range decodes
  logic is_nl, is_esc, is_csi, is_colon, is_semi;
  logic is_fe, is_inter, is_digit, is_param, is_privlead, is_final;

  assign is_nl       = (byte_i == tebc_pkg::CH_NEWLINE);
  assign is_esc      = (byte_i == tebc_pkg::CH_ESC);
  assign is_csi      = (byte_i == tebc_pkg::CH_CSI);
  assign is_colon    = (byte_i == tebc_pkg::CH_COLON);
  assign is_semi     = (byte_i == tebc_pkg::CH_SEMI);
  assign is_fe       = (byte_i >= 8'h40) && (byte_i <= 8'h5f);
  assign is_inter    = (byte_i >= 8'h20) && (byte_i <= 8'h2f);
  assign is_digit    = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign is_param    = (byte_i >= 8'h30) && (byte_i <= 8'h3f);
  assign is_privlead = (byte_i >= 8'h3c) && (byte_i <= 8'h3f);
  assign is_final    = (byte_i >= 8'h40) && (byte_i <= 8'h7e);

  logic priv_cont, priv_open;
  assign priv_cont = (st_i.run == tebc_pkg::RUN_PRIV) && is_param;
  assign priv_open = st_i.intro && is_privlead;

  // next parser state
  always_comb begin
    st_nxt.mode  = st_i.mode;
    st_nxt.intro = 1'b0;
    st_nxt.run   = tebc_pkg::RUN_NONE;
    unique case (st_i.mode)
      tebc_pkg::MODE_TEXT: begin
        priority if (is_nl) begin
          st_nxt.mode = tebc_pkg::MODE_TEXT;
        end else if (is_esc) begin
          st_nxt.mode = tebc_pkg::MODE_ESC;
        end else begin
          st_nxt.run = tebc_pkg::RUN_CONTENT;
        end
      end
      tebc_pkg::MODE_ESC: begin
        if (is_fe && is_csi) begin
          st_nxt.mode  = tebc_pkg::MODE_PARAM;
          st_nxt.intro = 1'b1;
        end else begin
          st_nxt.mode = tebc_pkg::MODE_TEXT;
        end
      end
      tebc_pkg::MODE_PARAM: begin
        priority if (priv_cont) begin
          st_nxt.run = tebc_pkg::RUN_PRIV;
        end else if (is_inter) begin
          st_nxt.mode = tebc_pkg::MODE_INTER;
        end else if (is_digit) begin
          st_nxt.run = tebc_pkg::RUN_DIGIT;
        end else if (is_colon || is_semi) begin
          st_nxt.mode = tebc_pkg::MODE_PARAM;
        end else if (priv_open) begin
          st_nxt.run = tebc_pkg::RUN_PRIV;
        end else begin
          st_nxt.mode = tebc_pkg::MODE_TEXT;
        end
      end
      tebc_pkg::MODE_INTER: begin
        if (!is_inter) begin
          st_nxt.mode = tebc_pkg::MODE_TEXT;
        end
      end
      default: st_nxt.mode = tebc_pkg::MODE_TEXT;
    endcase
  end

  // byte role and run / sequence flags
  always_comb begin
    part_o.kind      = tebc_pkg::K_UNKNOWN;
    part_o.run_start = 1'b0;
    part_o.seq_end   = 1'b0;
    unique case (st_i.mode)
      tebc_pkg::MODE_TEXT: begin
        priority if (is_nl) begin
          part_o.kind = tebc_pkg::K_NEWLINE;
        end else if (is_esc) begin
          part_o.kind = tebc_pkg::K_ESC;
        end else begin
          part_o.kind      = tebc_pkg::K_CONTENT;
          part_o.run_start = (st_i.run != tebc_pkg::RUN_CONTENT);
        end
      end
      tebc_pkg::MODE_ESC: begin
        part_o.kind    = is_fe ? tebc_pkg::K_FE : tebc_pkg::K_UNKNOWN;
        part_o.seq_end = !(is_fe && is_csi);
      end
      tebc_pkg::MODE_PARAM: begin
        priority if (priv_cont) begin
          part_o.kind = tebc_pkg::K_PRIV;
        end else if (is_inter) begin
          part_o.kind = tebc_pkg::K_INTER;
        end else if (is_digit) begin
          part_o.kind      = tebc_pkg::K_DIGIT;
          part_o.run_start = (st_i.run != tebc_pkg::RUN_DIGIT);
        end else if (is_colon) begin
          part_o.kind = tebc_pkg::K_COLON;
        end else if (is_semi) begin
          part_o.kind = tebc_pkg::K_SEMI;
        end else if (priv_open) begin
          part_o.kind      = tebc_pkg::K_PRIV;
          part_o.run_start = 1'b1;
        end else if (is_final) begin
          part_o.kind    = tebc_pkg::K_FINAL;
          part_o.seq_end = 1'b1;
        end else begin
          part_o.seq_end = 1'b1;
        end
      end
      tebc_pkg::MODE_INTER: begin
        priority if (is_inter) begin
          part_o.kind = tebc_pkg::K_INTER;
        end else if (is_final) begin
          part_o.kind    = tebc_pkg::K_FINAL;
          part_o.seq_end = 1'b1;
        end else begin
          part_o.seq_end = 1'b1;
        end
      end
      default: part_o.seq_end = 1'b1;
    endcase
  end

endmodule
